[rtl/core/psfp_pkg.sv]
package psfp_pkg;

	localparam int BODY_BYTES    = 30;
	localparam int READING_COUNT = 12;

	// Two store bytes per reading, frame bytes 4 onward.
	localparam int STORE_DEPTH = 2 * READING_COUNT;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	localparam int POS_W = 5;
	localparam int IDX_W = 4;

	localparam logic [POS_W-1:0] POS_CHK_HI     = POS_W'(BODY_BYTES - 2);
	localparam logic [POS_W-1:0] POS_FIRST_READ = POS_W'(2);
	localparam logic [IDX_W-1:0] LAST_IDX       = IDX_W'(READING_COUNT - 1);

	localparam logic [7:0] FIRST_START_RESET  = 8'd66;
	localparam logic [7:0] SECOND_START_RESET = 8'd77;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_START  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_START = 1'd1;

	typedef enum logic [1:0] {
		ALU_ADD = 2'b01,
		ALU_CMP = 2'b10
	} alu_op_t;

	typedef struct packed {
		alu_op_t     op;
		logic [15:0] a;
		logic [15:0] b;
	} alu_req_t;

endpackage

[rtl/core/psfp_alu.sv]
module psfp_alu (
	input  psfp_pkg::alu_req_t req,
	output logic [15:0]        sum,
	output logic               equal
);

	always_comb begin
		sum   = '0;
		equal = 1'b0;
		case (req.op)
			psfp_pkg::ALU_ADD: begin
				sum = req.a + req.b;
			end
			psfp_pkg::ALU_CMP: begin
				equal = (req.a == req.b);
			end
			default: begin
				sum   = '0;
				equal = 1'b0;
			end
		endcase
	end

endmodule

[rtl/core/psfp_store.sv]
module psfp_store (
	input  logic                        clk,
	input  logic                        we,
	input  logic [psfp_pkg::ADDR_W-1:0] waddr,
	input  logic [7:0]                  wdata,
	input  logic [psfp_pkg::ADDR_W-1:0] raddr,
	output logic [7:0]                  rdata_q
);

	logic [7:0] mem_q [psfp_pkg::STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

endmodule

[rtl/core/particle_sensor_frame_parser.sv]
// Parses 32-byte particle sensor frames from a byte stream and emits the twelve
// 16-bit readings of each frame whose checksum matches. The checksum high byte
// is only latched in the cycle that accepts it, and every other byte takes one or
// two further steps on the single shared adder/comparator, which both sums the
// frame and compares start bytes and the checksum. After a good frame the
// readings are read back from a byte store with separate read and write ports,
// each through read-high, read-low, latch and output steps, waiting in the last
// while the receiver holds off ready; no byte is accepted until the last reading has been taken.
module particle_sensor_frame_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     rx_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [psfp_pkg::IDX_W-1:0]     reading_index,
	output logic [15:0]                    reading_value,
	output logic                           last_reading,
	input  logic                           cfg_we,
	input  logic [psfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CMP   = 7'b0000010,
		S_ADD   = 7'b0000100,
		S_RD_HI = 7'b0001000,
		S_RD_LO = 7'b0010000,
		S_LATCH = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'b001,
		PH_SECOND = 3'b010,
		PH_BODY   = 3'b100
	} phase_t;

	state_t                         state_q;
	phase_t                         phase_q;
	logic [psfp_pkg::POS_W-1:0]     pos_q;
	logic [15:0]                    sum_q;
	logic [7:0]                     chk_hi_q;
	logic [7:0]                     byte_q;
	logic [7:0]                     first_q;
	logic [7:0]                     second_q;
	logic [psfp_pkg::IDX_W-1:0]     k_q;
	logic [7:0]                     hi_q;
	logic                           out_valid_q;

	psfp_pkg::alu_req_t             alu_req;
	logic [15:0]                    alu_sum;
	logic                           alu_equal;

	logic                           st_we;
	logic [psfp_pkg::POS_W-1:0]     wr_off;
	logic [psfp_pkg::POS_W-1:0]     rd_off;
	logic [psfp_pkg::ADDR_W-1:0]    st_raddr;
	logic [7:0]                     st_rdata;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		alu_req.op = psfp_pkg::ALU_CMP;
		alu_req.a  = {8'd0, byte_q};
		alu_req.b  = {8'd0, first_q};
		if (state_q == S_ADD) begin
			alu_req.op = psfp_pkg::ALU_ADD;
			alu_req.a  = sum_q;
			alu_req.b  = {8'd0, byte_q};
		end else if (phase_q == PH_SECOND) begin
			alu_req.b = {8'd0, second_q};
		end else if (phase_q == PH_BODY) begin
			alu_req.a = {chk_hi_q, byte_q};
			alu_req.b = sum_q;
		end
	end

	psfp_alu u_alu (
		.req   (alu_req),
		.sum   (alu_sum),
		.equal (alu_equal)
	);

	// Body position 2 is frame byte 4, the high byte of the first reading.
	assign wr_off = pos_q - psfp_pkg::POS_FIRST_READ;
	assign st_we  = (state_q == S_ADD) && (phase_q == PH_BODY) &&
		(pos_q >= psfp_pkg::POS_FIRST_READ) &&
		({1'b0, wr_off} < (psfp_pkg::POS_W + 1)'(psfp_pkg::STORE_DEPTH));

	assign rd_off   = ({1'b0, k_q} << 1) | {4'd0, (state_q != S_RD_HI)};
	assign st_raddr = rd_off[psfp_pkg::ADDR_W-1:0];

	psfp_store u_store (
		.clk     (clk),
		.we      (st_we),
		.waddr   (wr_off[psfp_pkg::ADDR_W-1:0]),
		.wdata   (byte_q),
		.raddr   (st_raddr),
		.rdata_q (st_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= psfp_pkg::FIRST_START_RESET;
			second_q <= psfp_pkg::SECOND_START_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				psfp_pkg::REG_FIRST_START: begin
					first_q <= cfg_data;
				end
				psfp_pkg::REG_SECOND_START: begin
					second_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			phase_q       <= PH_HUNT;
			pos_q         <= '0;
			sum_q         <= '0;
			chk_hi_q      <= '0;
			k_q           <= '0;
			out_valid_q   <= 1'b0;
			byte_q        <= '0;
			hi_q          <= '0;
			reading_index <= '0;
			reading_value <= '0;
			last_reading  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						byte_q <= rx_byte;
						if (phase_q == PH_BODY && pos_q < psfp_pkg::POS_CHK_HI) begin
							state_q <= S_ADD;
						end else if (phase_q == PH_BODY && pos_q == psfp_pkg::POS_CHK_HI) begin
							chk_hi_q <= rx_byte;
							pos_q    <= pos_q + 1'b1;
						end else begin
							state_q <= S_CMP;
						end
					end
				end
				S_CMP: begin
					state_q <= S_IDLE;
					case (phase_q)
						PH_SECOND: begin
							if (alu_equal) begin
								state_q <= S_ADD;
							end else begin
								phase_q <= PH_HUNT;
							end
						end
						PH_BODY: begin
							// Checksum low byte: frame ends here either way.
							phase_q <= PH_HUNT;
							pos_q   <= '0;
							if (alu_equal) begin
								k_q     <= '0;
								state_q <= S_RD_HI;
							end
						end
						default: begin
							phase_q <= PH_HUNT;
							if (alu_equal) begin
								sum_q   <= {8'd0, byte_q};
								phase_q <= PH_SECOND;
							end
						end
					endcase
				end
				S_ADD: begin
					sum_q   <= alu_sum;
					state_q <= S_IDLE;
					if (phase_q == PH_SECOND) begin
						pos_q   <= '0;
						phase_q <= PH_BODY;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				S_RD_HI: begin
					state_q <= S_RD_LO;
				end
				S_RD_LO: begin
					hi_q    <= st_rdata;
					state_q <= S_LATCH;
				end
				S_LATCH: begin
					reading_index <= k_q;
					reading_value <= {hi_q, st_rdata};
					last_reading  <= (k_q == psfp_pkg::LAST_IDX);
					out_valid_q   <= 1'b1;
					state_q       <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (last_reading) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_RD_HI;
						end
					end
				end
				default: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

[bench/tb_particle_sensor_frame_parser.sv]
`timescale 1ns / 100ps

module tb_particle_sensor_frame_parser;
	import psfp_pkg::*;

	localparam int FRAME_BYTES = BODY_BYTES + 2;

	typedef enum logic [2:0] {
		SEEK_FIRST  = 3'b001,
		SEEK_SECOND = 3'b010,
		IN_BODY     = 3'b100
	} parse_state_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [15:0]      word;
		logic             is_last;
	} reading_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           rx_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic [IDX_W-1:0]     reading_index;
	logic [15:0]          reading_value;
	logic                 last_reading;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;

	// Mirror of the parser state and its two start byte registers.
	parse_state_t pstate;
	logic [4:0]   body_count;
	logic [15:0]  frame_sum;
	logic [7:0]   sum_hi;
	logic [7:0]   reading_store [2*READING_COUNT];
	logic [7:0]   first_start;
	logic [7:0]   second_start;

	reading_t     pending_readings [$];
	logic [7:0]   frame_buf [FRAME_BYTES];
	logic [15:0]  frame_readings [READING_COUNT];

	int sender_idle_pct   = 12;
	int receiver_idle_pct = 74;
	int bytes_sent        = 0;
	int good_frames       = 0;
	int readings_checked  = 0;
	int errors            = 0;

	particle_sensor_frame_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.reading_index (reading_index),
		.reading_value (reading_value),
		.last_reading  (last_reading),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic reset_tracker();
		pstate       = SEEK_FIRST;
		body_count   = '0;
		frame_sum    = '0;
		sum_hi       = '0;
		first_start  = FIRST_START_RESET;
		second_start = SECOND_START_RESET;
		foreach (reading_store[i]) reading_store[i] = '0;
	endtask

	// Advances the mirrored parser by one accepted byte and queues the readings
	// of a frame whose checksum matches.
	task automatic track_byte(input logic [7:0] b);
		reading_t r;
		int k;
		case (pstate)
			SEEK_SECOND: begin
				if (b == second_start) begin
					frame_sum  = frame_sum + 16'(b);
					body_count = '0;
					pstate     = IN_BODY;
				end else begin
					pstate = SEEK_FIRST;
				end
			end
			IN_BODY: begin
				if (body_count < 5'(BODY_BYTES - 2)) begin
					frame_sum = frame_sum + 16'(b);
					if (body_count >= 5'd2 && body_count < 5'(2 + 2*READING_COUNT))
						reading_store[body_count - 5'd2] = b;
					body_count = body_count + 5'd1;
				end else if (body_count == 5'(BODY_BYTES - 2)) begin
					sum_hi     = b;
					body_count = body_count + 5'd1;
				end else begin
					pstate     = SEEK_FIRST;
					body_count = '0;
					if ({sum_hi, b} == frame_sum) begin
						good_frames++;
						for (k = 0; k < READING_COUNT; k++) begin
							r.idx     = IDX_W'(k);
							r.word    = {reading_store[2*k], reading_store[2*k+1]};
							r.is_last = (k == READING_COUNT - 1);
							pending_readings.push_back(r);
						end
					end
				end
			end
			default: begin
				pstate = SEEK_FIRST;
				if (b == first_start) begin
					frame_sum = 16'(b);
					pstate    = SEEK_SECOND;
				end
			end
		endcase
	endtask

	// Entered and left at a falling edge; valid is left high for the next beat.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		track_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_span(input int lo, input int hi);
		int i;
		for (i = lo; i <= hi; i++) send_byte(frame_buf[i]);
	endtask

	// Drops valid and lets the block drain, including bytes still in flight
	// that produce no reading.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (idx == REG_FIRST_START)
			first_start = val;
		else
			second_start = val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_idle_mix(input int s_pct, input int r_pct);
		wait_idle();
		sender_idle_pct   = s_pct;
		receiver_idle_pct = r_pct;
	endtask

	task automatic fill_random_readings();
		int i;
		for (i = 0; i < READING_COUNT; i++) begin
			case ($urandom_range(7))
				0:       frame_readings[i] = 16'h0000;
				1:       frame_readings[i] = 16'hFFFF;
				default: frame_readings[i] = 16'($urandom);
			endcase
		end
	endtask

	// Builds a frame around the current start bytes and readings.
	task automatic build_frame(input bit bad_sum, input bit odd_length);
		logic [15:0] sum;
		int i;
		frame_buf[0] = first_start;
		frame_buf[1] = second_start;
		frame_buf[2] = odd_length ? 8'($urandom) : 8'h00;
		frame_buf[3] = odd_length ? 8'($urandom) : 8'h1C;
		for (i = 0; i < READING_COUNT; i++)
			{frame_buf[4 + 2*i], frame_buf[5 + 2*i]} = frame_readings[i];
		frame_buf[FRAME_BYTES-4] = 8'($urandom);
		frame_buf[FRAME_BYTES-3] = 8'($urandom);
		sum = '0;
		for (i = 0; i < FRAME_BYTES - 2; i++) sum = sum + 16'(frame_buf[i]);
		if (bad_sum) sum = sum ^ 16'($urandom_range(65535, 1));
		{frame_buf[FRAME_BYTES-2], frame_buf[FRAME_BYTES-1]} = sum;
	endtask

	task automatic report_error(input string msg);
		if (errors < 10) $display("%0t: mismatch: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk) begin : check_reading
		reading_t want;
		if (arst_n && out_valid && out_ready) begin
			readings_checked++;
			if (pending_readings.size() == 0) begin
				report_error($sformatf("unexpected reading idx=%0d value=%h last=%b",
					reading_index, reading_value, last_reading));
			end else begin
				want = pending_readings.pop_front();
				if (reading_index !== want.idx)
					report_error($sformatf("reading_index expected %0d got %0d",
						want.idx, reading_index));
				if (reading_value !== want.word)
					report_error($sformatf("reading_value (idx %0d) expected %h got %h",
						want.idx, want.word, reading_value));
				if (last_reading !== want.is_last)
					report_error($sformatf("last_reading (idx %0d) expected %b got %b",
						want.idx, want.is_last, last_reading));
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// Readings at both extremes, framed by the reset start bytes.
	task automatic test_default_frame();
		int i;
		for (i = 0; i < READING_COUNT; i++)
			frame_readings[i] = i[0] ? 16'hFFFF : 16'h0000;
		build_frame(1'b0, 1'b0);
		send_span(0, FRAME_BYTES - 1);
		wait_idle();
	endtask

	// A wrong second start byte is thrown away, not taken as a new first one.
	task automatic test_start_hunting();
		send_byte(first_start);
		send_byte(first_start);
		send_byte(second_start);
		send_byte(8'h00);
		send_byte(8'hFF);
		fill_random_readings();
		build_frame(1'b0, 1'b1);
		send_span(0, FRAME_BYTES - 1);
		wait_idle();
	endtask

	// A frame with a wrong checksum gives no reading at all.
	task automatic test_bad_checksum();
		fill_random_readings();
		build_frame(1'b1, 1'b0);
		send_span(0, FRAME_BYTES - 1);
		wait_idle();
	endtask

	// The frame is framed by start bytes at opposite extremes, and new start
	// bytes written after its first ten bytes must not disturb it.
	task automatic test_config_mid_frame();
		write_reg(REG_FIRST_START, 8'hFF);
		write_reg(REG_SECOND_START, 8'h00);
		fill_random_readings();
		build_frame(1'b0, 1'b0);
		send_span(0, 9);
		wait_idle();
		write_reg(REG_FIRST_START, 8'h00);
		write_reg(REG_SECOND_START, 8'hFF);
		send_span(10, FRAME_BYTES - 1);
		wait_idle();
	endtask

	initial begin : run
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		rx_byte   = 8'h00;
		cfg_we    = 1'b0;
		cfg_index = REG_FIRST_START;
		cfg_data  = 8'h00;
		reset_tracker();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_default_frame();
		test_bad_checksum();

		set_idle_mix(74, 12);
		test_start_hunting();

		set_idle_mix(0, 0);
		test_config_mid_frame();

		$display("Sent %0d bytes under three idle mixes with reset and extreme start bytes,",
			bytes_sent);
		$display("%0d frames passed checksum, %0d readings checked, %0d mismatches.",
			good_frames, readings_checked, errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/psfp_pkg.sv
rtl/core/psfp_alu.sv
rtl/core/psfp_store.sv
rtl/core/particle_sensor_frame_parser.sv
bench/tb_particle_sensor_frame_parser.sv
